// File: rtl/core/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache core.
// Used by lru_key_value_cache_core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

   // Width of keys and values.
   localparam int DATA_W = 32;

   // Width and reset value of the entries-in-use register.
   localparam int CSR_W = 5;
   localparam logic [CSR_W-1:0] CSR_RESET = 5'd16;

   // Value reported by a get that misses.
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

   // Request operation codes.
   typedef enum logic {
      OP_GET = 1'b0,
      OP_SET = 1'b1
   } op_type;

   // One request.
   typedef struct packed {
      op_type                   operation;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } req_type;

   // One response.
   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] read_value;
      logic                     evicted;
      logic signed [DATA_W-1:0] evicted_key;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/lkvc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; holds old data when a read and a write hit the same address.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read; the read returns the contents before the write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg for types and constants and on lkvc_ram for the data store.
//
// Usage:
//  - Requests arrive on req_valid/req_ready/req_data. A get looks a key up; a set
//    updates a present key or inserts a new one, evicting the least recently
//    used entry when the cache is at capacity.
//  - Each request gives exactly one response on rsp_valid/rsp_ready/rsp_data.
//  - csr_valid/csr_ready/csr_data writes the entry capacity; csr_ready is always high.
//    Write it only while no request is in flight; the block does not enforce this.
//  - Path: a request waits in the input register until the response register is
//    free, then moves into the response register and onto the response port.
//  - Throughput: one request per cycle unless the receiver stalls. All keys are
//    compared in parallel against the request held in the input register, and the
//    age, valid and key flops plus the data RAM are updated in that same cycle.
//  - Reset: every entry becomes invalid, occupancy returns to zero and the
//    entries-in-use register returns to 16. No clearing pass is needed.
//  - When the receiver stalls, the response is held, the request in the input
//    register waits, and req_ready falls once that register is occupied.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_core #(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire lkvc_pkg::req_type                   req_data,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output lkvc_pkg::rsp_type                        rsp_data,
   // configuration channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lkvc_pkg::CSR_W-1:0]          csr_data
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
   localparam int DW    = lkvc_pkg::DATA_W;

   // Configuration register.
   logic [lkvc_pkg::CSR_W-1:0] entries_ff;

   // Input register.
   logic              in_valid_ff;
   lkvc_pkg::req_type req_ff;

   // Tag state: keys for the parallel compare, valid bits, ages, occupancy.
   logic [DW-1:0]    key_ff   [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [IDX_W-1:0] age_ff   [MAX_ENTRIES];
   logic [OCC_W-1:0] occ_ff;

   // Response register (the data half lives in the RAM read register).
   logic rsp_valid_ff;
   logic found_ff;
   logic get_ff;
   logic evicted_ff;
   logic [2*DW-1:0] ram_rd;

   // Lookup results.
   logic [MAX_ENTRIES-1:0] hit_vec;
   logic [MAX_ENTRIES-1:0] victim_vec;
   logic                   found;
   logic [IDX_W-1:0]       hit_idx;
   logic [IDX_W-1:0]       victim_idx;
   logic [IDX_W-1:0]       free_idx;
   logic [IDX_W-1:0]       sel_idx;
   logic [IDX_W-1:0]       hit_age;
   logic [IDX_W-1:0]       oldest_age;
   logic [OCC_W-1:0]       capacity;
   logic                   is_set;
   logic                   insert;
   logic                   evict;
   logic                   advance;

   // Configuration transfers are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= lkvc_pkg::CSR_RESET;
      end else if (csr_valid) begin
         entries_ff <= csr_data;
      end
   end

   // Effective capacity: zero acts as one, anything above the store size saturates.
   always_comb begin
      if (entries_ff == '0) begin
         capacity = OCC_W'(1);
      end else if (int'(entries_ff) > MAX_ENTRIES) begin
         capacity = OCC_W'(MAX_ENTRIES);
      end else begin
         capacity = OCC_W'(entries_ff);
      end
   end

   // Handshake: the request in the input register moves on when the response
   // register is empty or is being drained in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // Parallel key compare and victim search. Valid ages are unique and run from
   // zero to occupancy minus one, so the victim is the entry at the oldest age.
   assign oldest_age = IDX_W'(occ_ff - OCC_W'(1));

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_vec[i]    = valid_ff[i] && (key_ff[i] == req_ff.key);
         victim_vec[i] = valid_ff[i] && (age_ff[i] == oldest_age);
      end
   end

   // Index encoders: highest matching entry for hits and victims, lowest free slot.
   always_comb begin
      hit_idx    = '0;
      victim_idx = '0;
      free_idx   = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (victim_vec[i]) begin
            victim_idx = IDX_W'(i);
         end
      end
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign found   = |hit_vec;
   assign hit_age = age_ff[hit_idx];
   assign is_set  = (req_ff.operation == lkvc_pkg::OP_SET);
   assign insert  = is_set && !found;
   assign evict   = insert && (occ_ff >= capacity);

   // Slot that this request touches.
   always_comb begin
      if (found) begin
         sel_idx = hit_idx;
      end else if (evict) begin
         sel_idx = victim_idx;
      end else begin
         sel_idx = free_idx;
      end
   end

   // Recency update. A hit ages only the entries younger than it; an insert
   // ages every other valid entry. A get that misses leaves everything alone.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else if (advance && (found || insert)) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (IDX_W'(i) == sel_idx) begin
               age_ff[i] <= '0;
            end else if (valid_ff[i] && (insert || (age_ff[i] < hit_age))) begin
               age_ff[i] <= age_ff[i] + IDX_W'(1);
            end
         end
         if (insert) begin
            valid_ff[sel_idx] <= 1'b1;
            if (!evict) begin
               occ_ff <= occ_ff + OCC_W'(1);
            end
         end
      end
   end

   // Key store for the compare; written only on insertion.
   always_ff @(posedge clock) begin
      if (advance && insert) begin
         key_ff[sel_idx] <= req_ff.key;
      end
   end

   // Key and value pairs. The read port serves the hit on a get and the victim
   // on an evicting set; its output register is part of the response register.
   lkvc_ram #(
      .WIDTH (2 * DW),
      .DEPTH (MAX_ENTRIES)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (advance && is_set),
      .wr_addr (sel_idx),
      .wr_data ({req_ff.key, req_ff.value}),
      .rd_en   (advance),
      .rd_addr (found ? hit_idx : victim_idx),
      .rd_data (ram_rd)
   );

   // Response register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         found_ff   <= found;
         get_ff     <= !is_set;
         evicted_ff <= evict;
      end
   end

   // Response payload.
   always_comb begin
      rsp_data.found   = found_ff;
      rsp_data.evicted = evicted_ff;
      if (!get_ff) begin
         rsp_data.read_value = '0;
      end else if (found_ff) begin
         rsp_data.read_value = ram_rd[DW-1:0];
      end else begin
         rsp_data.read_value = lkvc_pkg::MISS_VALUE;
      end
      rsp_data.evicted_key = evicted_ff ? ram_rd[2*DW-1:DW] : '0;
   end

   // Occupancy always matches the number of valid entries.
   a_occ_count : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("Occupancy disagrees with the valid bits.");

   // A key is never held by two valid entries.
   a_unique_hit : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> $onehot0(hit_vec))
      else $error("Key matches more than one entry.");

   // An evicting set finds exactly one least recent entry.
   a_one_victim : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && evict) |-> $onehot(victim_vec))
      else $error("Eviction without a unique least recent entry.");

   // An insert without eviction always finds a free slot.
   a_free_slot : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && insert && !evict) |-> !valid_ff[free_idx])
      else $error("Insert found no free entry.");

endmodule

`default_nettype wire

// File: tb/lru_key_value_cache_core_test.sv
// Self-checking testbench for lru_key_value_cache_core: a short directed table, then random
// get/set traffic over several capacity settings; rows that give an answer are checked against
// it, others against an LRU cache model kept here. Depends only on lkvc_pkg and the core itself.
`timescale 1ns / 1ps

module lru_key_value_cache_core_test;

   localparam int DATA_W = lkvc_pkg::DATA_W;
   localparam int CSR_W = lkvc_pkg::CSR_W;
   localparam int SLOTS = 16;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int PHASES = 10;
   localparam int DRAIN_CYCLES = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT = 500;
   localparam logic [DATA_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   // Patterns the receiver cycles through when deciding rsp_ready.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_HOLD,
      RX_PULSE
   } rx_pattern_type;

   // One row of the directed table: either a register write or a request.
   typedef struct {
      bit                 is_setting;
      logic [CSR_W-1:0]   setting;
      lkvc_pkg::req_type  request;
      bit                 typed;
      lkvc_pkg::rsp_type  answer;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lkvc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lkvc_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_data = '0;

   // Cache contents as the block should hold them.
   logic [DATA_W-1:0] held_key [SLOTS];
   logic [DATA_W-1:0] held_value [SLOTS];
   bit                held_valid [SLOTS];
   int unsigned       held_age [SLOTS];
   int unsigned       held_count = 0;
   logic [CSR_W-1:0]  entries_setting = lkvc_pkg::CSR_RESET;

   lkvc_pkg::rsp_type pending_answers[$];
   stim_row_type      directed_rows[$];
   int                error_count = 0;
   int                answers_seen = 0;
   int                requests_sent = 0;
   int                get_hits = 0;
   int                evictions = 0;
   int                setting_writes = 0;
   int                burst_left = 0;
   int                idle_cycles = 0;
   rx_pattern_type    rx_pattern = RX_OPEN;
   int                rx_spell = 0;

   lru_key_value_cache_core #(
      .MAX_ENTRIES(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // A setting of zero behaves as one entry, and anything above the slot count as the slot count.
   function automatic int unsigned effective_capacity(logic [CSR_W-1:0] setting);
      int unsigned cap;
      cap = setting;
      if (cap == 0) cap = 1;
      if (cap > SLOTS) cap = SLOTS;
      return cap;
   endfunction

   // Make one slot the most recent; valid slots younger than the limit grow one older.
   function automatic void make_recent(int slot, int unsigned limit);
      for (int i = 0; i < SLOTS; i++) begin
         if (held_valid[i] && i != slot && held_age[i] < limit) held_age[i]++;
      end
      held_age[slot] = 0;
   endfunction

   // Apply one request to the cache contents and return the response it earns.
   function automatic lkvc_pkg::rsp_type cache_access(lkvc_pkg::req_type r);
      lkvc_pkg::rsp_type res;
      bit                hit;
      int                hit_slot;
      int                slot;
      bit                any;
      int unsigned       oldest;
      res = '0;
      hit = 1'b0;
      hit_slot = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (held_valid[i] && held_key[i] == r.key) begin
            hit = 1'b1;
            hit_slot = i;
         end
      end
      res.found = hit;
      if (r.operation == lkvc_pkg::OP_GET) begin
         if (hit) begin
            res.read_value = held_value[hit_slot];
            make_recent(hit_slot, held_age[hit_slot]);
         end else begin
            res.read_value = lkvc_pkg::MISS_VALUE;
         end
      end else if (hit) begin
         held_value[hit_slot] = r.value;
         make_recent(hit_slot, held_age[hit_slot]);
      end else begin
         slot = 0;
         if (held_count >= effective_capacity(entries_setting)) begin
            // The victim is the valid slot that has gone longest without use.
            any = 1'b0;
            oldest = 0;
            for (int i = 0; i < SLOTS; i++) begin
               if (held_valid[i] && (!any || held_age[i] > oldest)) begin
                  oldest = held_age[i];
                  slot = i;
                  any = 1'b1;
               end
            end
            res.evicted = 1'b1;
            res.evicted_key = held_key[slot];
            held_valid[slot] = 1'b0;
            held_count--;
         end else begin
            // Otherwise the lowest free slot is taken.
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!held_valid[i]) slot = i;
            end
         end
         held_key[slot] = r.key;
         held_value[slot] = r.value;
         held_valid[slot] = 1'b1;
         held_age[slot] = 0;
         make_recent(slot, 32'hFFFF_FFFF);
         held_count++;
      end
      return res;
   endfunction

   function automatic lkvc_pkg::rsp_type answer(bit found, logic [DATA_W-1:0] rd, bit ev,
                                                logic [DATA_W-1:0] ek);
      lkvc_pkg::rsp_type a;
      a.found = found;
      a.read_value = rd;
      a.evicted = ev;
      a.evicted_key = ek;
      return a;
   endfunction

   function automatic stim_row_type request_row(lkvc_pkg::op_type op, logic [DATA_W-1:0] k,
                                                logic [DATA_W-1:0] v, bit typed,
                                                lkvc_pkg::rsp_type a);
      stim_row_type row;
      row.is_setting = 1'b0;
      row.setting = '0;
      row.request.operation = op;
      row.request.key = k;
      row.request.value = v;
      row.typed = typed;
      row.answer = a;
      return row;
   endfunction

   function automatic stim_row_type setting_row(logic [CSR_W-1:0] setting);
      stim_row_type row;
      row = request_row(lkvc_pkg::OP_GET, '0, '0, 1'b0, '0);
      row.is_setting = 1'b1;
      row.setting = setting;
      return row;
   endfunction

   // One of the words at the corners of the 32-bit range.
   function automatic logic [DATA_W-1:0] corner_word();
      case ($urandom_range(0, 3))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2: return '0;
         default: return ALL_ONES;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      $display("[%0t] response %0d: %s got %h, expected %h", $time, answers_seen, what,
               got, want);
      error_count++;
   endtask

   // Offer one request from a falling edge and hold it until the transfer; the
   // expected response is recorded at the edge where the block takes it.
   task automatic send_request(lkvc_pkg::req_type r, bit typed, lkvc_pkg::rsp_type a);
      lkvc_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = cache_access(r);
      pending_answers.push_back(typed ? a : predicted);
      requests_sent++;
      if (r.operation == lkvc_pkg::OP_GET && predicted.found) get_hits++;
      if (predicted.evicted) evictions++;
      @(negedge clock);
   endtask

   // The sender works in bursts, and valid drops between bursts.
   task automatic pace_sender();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   // The register is only written once every response is back and the pipeline is empty.
   task automatic write_entries(logic [CSR_W-1:0] setting);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= setting;
      do @(posedge clock); while (!csr_ready);
      entries_setting = setting;
      setting_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: runs of one pattern at a time, each for a random number of cycles.
   always @(negedge clock) begin
      if (rx_spell == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         rx_spell = (rx_pattern == RX_HOLD) ? $urandom_range(1, 16) : $urandom_range(4, 40);
      end
      rx_spell = rx_spell - 1;
      case (rx_pattern)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_COIN: rsp_ready <= $urandom_range(0, 1);
         RX_HOLD: rsp_ready <= 1'b0;
         default: rsp_ready <= (rx_spell % 3 != 0);
      endcase
   end

   // Every response transfer is compared with the oldest outstanding expectation.
   always @(posedge clock) begin : check_responses
      lkvc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_data.read_value, '0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch("found", rsp_data.found, want.found);
            if (rsp_data.read_value !== want.read_value)
               report_mismatch("read_value", rsp_data.read_value, want.read_value);
            if (rsp_data.evicted !== want.evicted)
               report_mismatch("evicted", rsp_data.evicted, want.evicted);
            if (rsp_data.evicted_key !== want.evicted_key)
               report_mismatch("evicted_key", rsp_data.evicted_key, want.evicted_key);
         end
      end
   end

   // Watchdog: too long without any transfer on any channel means the block is stuck.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("lru_key_value_cache_core_test: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      lkvc_pkg::req_type r;
      stim_row_type      row;
      logic [CSR_W-1:0]  phase_setting [PHASES];
      logic [DATA_W-1:0] key_pool [32];
      int                pool_size;
      int                pick;

      for (int i = 0; i < SLOTS; i++) begin
         held_key[i] = '0;
         held_value[i] = '0;
         held_valid[i] = 1'b0;
         held_age[i] = 0;
      end

      // Directed table. Recency after the first ten rows, newest first:
      // all-ones, zero, KEY_MIN, KEY_MAX.
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, '0, '0, 1'b1,
                                          answer(0, lkvc_pkg::MISS_VALUE, 0, '0)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, KEY_MIN, KEY_MAX, 1'b1,
                                          answer(0, lkvc_pkg::MISS_VALUE, 0, '0)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, KEY_MIN, KEY_MAX, 1'b1,
                                          answer(0, '0, 0, '0)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, KEY_MAX, KEY_MIN, 1'b1,
                                          answer(0, '0, 0, '0)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, KEY_MIN, ALL_ONES, 1'b1,
                                          answer(1, KEY_MAX, 0, '0)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, KEY_MAX, '0, 1'b1,
                                          answer(1, KEY_MIN, 0, '0)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, KEY_MIN, ALL_ONES, 1'b1,
                                          answer(1, '0, 0, '0)));
      // A stored value of all ones must still come back as a hit.
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, KEY_MIN, '0, 1'b1,
                                          answer(1, ALL_ONES, 0, '0)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, '0, '0, 1'b1,
                                          answer(0, '0, 0, '0)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, ALL_ONES, 32'h1234_5678, 1'b1,
                                          answer(0, '0, 0, '0)));
      // Capacity set to zero acts as one and sits below the four entries held,
      // so each new key now pushes out the oldest one.
      directed_rows.push_back(setting_row(5'd0));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, 32'd1, 32'd5, 1'b1,
                                          answer(0, '0, 1, KEY_MAX)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, 32'd2, 32'd6, 1'b1,
                                          answer(0, '0, 1, KEY_MIN)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, 32'd2, '0, 1'b1,
                                          answer(1, 32'd6, 0, '0)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, 32'd2, 32'd7, 1'b1,
                                          answer(1, '0, 0, '0)));
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, KEY_MAX, '0, 1'b1,
                                          answer(0, lkvc_pkg::MISS_VALUE, 0, '0)));
      // The largest setting acts as the full slot count.
      directed_rows.push_back(setting_row(5'd31));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, 32'd3, KEY_MIN, 1'b0, '0));
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, '0, '0, 1'b0, '0));
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, 32'd1, '0, 1'b0, '0));
      directed_rows.push_back(setting_row(5'd1));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, KEY_MIN, '0, 1'b0, '0));
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, 32'd2, '0, 1'b0, '0));
      directed_rows.push_back(request_row(lkvc_pkg::OP_SET, KEY_MAX, KEY_MAX, 1'b0, '0));
      directed_rows.push_back(request_row(lkvc_pkg::OP_GET, ALL_ONES, '0, 1'b0, '0));

      phase_setting = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd17, 5'd1, 5'd8, 5'd2, 5'd12, 5'd0};
      phase_setting[PHASES - 1] = $urandom_range(0, 31);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_setting) begin
            write_entries(row.setting);
         end else begin
            pace_sender();
            send_request(row.request, row.typed, row.answer);
         end
      end

      // Random part: each phase picks a capacity and a key pool as large as it or a
      // little larger, so hits, updates and evictions all come up often.
      for (int phase = 0; phase < PHASES; phase++) begin
         write_entries(phase_setting[phase]);
         pool_size = effective_capacity(phase_setting[phase]) + $urandom_range(0, 6);
         for (int k = 0; k < pool_size; k++) key_pool[k] = $urandom();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pace_sender();
            r.operation = lkvc_pkg::op_type'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 85) r.key = key_pool[$urandom_range(0, pool_size - 1)];
            else if (pick < 92) r.key = corner_word();
            else r.key = $urandom();
            r.value = ($urandom_range(0, 9) == 0) ? corner_word() : $urandom();
            send_request(r, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_answers.size() != 0)
         report_mismatch("responses never returned", '0, pending_answers.size());

      $display("Sent %0d requests over %0d capacity settings (directed table plus %0d phases).",
               requests_sent, setting_writes, PHASES);
      $display("Gets that hit: %0d, evictions: %0d, responses checked: %0d, mismatches: %0d.",
               get_hits, evictions, answers_seen, error_count);
      if (error_count == 0) begin
         $display("lru_key_value_cache_core_test: clean");
      end else begin
         $display("lru_key_value_cache_core_test: errors");
      end
      $finish;
   end

endmodule

// File: lru_key_value_cache_core.f
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ram.sv
rtl/core/lru_key_value_cache_core.sv
tb/lru_key_value_cache_core_test.sv
